// ===== hw/rtl/step_sequencer_position_defines.svh =====
// assertion macros for the step sequencer lane
// no dependencies; included by the top level only
`ifndef STEP_SEQUENCER_POSITION_DEFINES_SVH
`define STEP_SEQUENCER_POSITION_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, clocked on i_clk, off during reset
`define SSP_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("ssp assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define SSP_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("ssp assertion failed");

`else

`define SSP_ASSERT_NOW(lbl, pre, post)
`define SSP_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ===== hw/rtl/ssp_pkg.sv =====
// shared types, codes and helpers of the step sequencer lane
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

    localparam int STEPS_DEFAULT       = 8;
    localparam int GUARD_TICKS_DEFAULT = 48;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_OWNER = 2'd1;
    localparam logic [1:0] REG_LANE  = 2'd2;
    localparam logic [1:0] REG_SEED  = 2'd3;

    localparam logic [15:0] SEED_RESET = 16'h0001;
    localparam logic [15:0] LFSR_MASK  = 16'hB400;

    // step modes
    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_SKIP   = 3'd1;
    localparam logic [2:0] MODE_SLIDE  = 3'd2;
    localparam logic [2:0] MODE_RESET  = 3'd3;
    localparam logic [2:0] MODE_P75    = 3'd4;
    localparam logic [2:0] MODE_P50    = 3'd5;
    localparam logic [2:0] MODE_P25    = 3'd6;

    // clock edge codes
    localparam logic [1:0] EDGE_NONE = 2'd0;
    localparam logic [1:0] EDGE_RISE = 2'd1;
    localparam logic [1:0] EDGE_FALL = 2'd2;

    // direction codes
    localparam logic [1:0] DIR_FWD  = 2'd0;
    localparam logic [1:0] DIR_BACK = 2'd1;
    localparam logic [1:0] DIR_PEND = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_PULSE,
        S_DONE
    } t_state;

    // configuration handed from the register file to the core
    typedef struct packed {
        logic [23:0] mode_table;
        logic [15:0] owner_table;
        logic [1:0]  lane_id;
        logic        seed_load;
        logic [15:0] seed_value;
    } t_cfg;

    function automatic logic [2:0] mode_of(input logic [23:0] tbl, input logic [2:0] s);
        logic [23:0] sh;
        sh = tbl >> (5'(s) * 5'd3);
        return sh[2:0];
    endfunction

    function automatic logic [1:0] owner_of(input logic [15:0] tbl, input logic [2:0] s);
        logic [15:0] sh;
        sh = tbl >> {s, 1'b0};
        return sh[1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ssp_if.sv =====
// valid/ready channel interfaces: sample words in, position words out
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface ssp_in_if ();
    logic       valid;
    logic       ready;
    logic [1:0] clock_edge;
    logic       reset_edge;
    logic       force_valid;
    logic [2:0] force_step;
    logic [1:0] direction;

    modport source (
        output valid, clock_edge, reset_edge, force_valid, force_step, direction,
        input  ready
    );
    modport sink (
        input  valid, clock_edge, reset_edge, force_valid, force_step, direction,
        output ready
    );
endinterface

interface ssp_out_if ();
    logic       valid;
    logic       ready;
    logic [2:0] step;
    logic       gate;
    logic       step_trigger;

    modport source (output valid, step, gate, step_trigger, input ready);
    modport sink (input valid, step, gate, step_trigger, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ssp_core.sv =====
// lane sequencer: decode of one sample word and the iterative step search
// depends on ssp_pkg and ssp_if
`timescale 1ns / 1ps
`default_nettype none

module ssp_core #(
    parameter int STEPS       = ssp_pkg::STEPS_DEFAULT,
    parameter int GUARD_TICKS = ssp_pkg::GUARD_TICKS_DEFAULT
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ssp_pkg::t_cfg i_cfg,
    ssp_in_if.sink             i_in,
    ssp_out_if.source          o_out
);

    localparam int          TRY_W      = $clog2(STEPS);
    localparam logic [TRY_W-1:0] TRY_LAST = TRY_W'(STEPS - 1);
    localparam logic [2:0]  LAST       = 3'(STEPS - 1);
    localparam logic [2:0]  TURN       = 3'(STEPS - 2);
    localparam logic [15:0] GUARD_LOAD = 16'(GUARD_TICKS);

    ssp_pkg::t_state r_state, n_state;

    logic [2:0]       r_pos,    n_pos;
    logic             r_back,   n_back;
    logic             r_pend_v, n_pend_v;
    logic [2:0]       r_pend_s, n_pend_s;
    logic [15:0]      r_guard,  n_guard;
    logic [15:0]      r_lfsr,   n_lfsr;
    logic             r_gate,   n_gate;
    logic             r_trig,   n_trig;
    logic [TRY_W-1:0] r_try,    n_try;
    logic             r_ov,     n_ov;

    // latched sample word
    logic [1:0] r_clk_e;
    logic       r_rst_e;
    logic       r_fv;
    logic [2:0] r_fs;
    logic [1:0] r_dir;

    // output word register
    logic [2:0] r_o_step;
    logic       r_o_gate;
    logic       r_o_trig;

    logic        w_accept;
    logic        w_out_free;
    logic [2:0]  w_mode_cur;
    logic        w_eff_pend;
    logic [2:0]  w_eff_step;
    logic [2:0]  w_adv_pos;
    logic        w_adv_back;
    logic [2:0]  w_adv_mode;
    logic        w_adv_prob;
    logic [15:0] w_lfsr_step;
    logic [1:0]  w_draw;
    logic        w_lose;
    logic [2:0]  w_jump_pos;

    function automatic logic [3:0] advance(input logic [2:0] pos, input logic back,
                                           input logic [1:0] dir);
        logic [2:0] p;
        logic       b;
        p = pos;
        b = back;
        case (dir)
            ssp_pkg::DIR_FWD: begin
                p = (pos >= LAST) ? 3'd0 : pos + 3'd1;
            end
            ssp_pkg::DIR_BACK: begin
                p = (pos == 3'd0) ? LAST : pos - 3'd1;
            end
            default: begin
                if (back) begin
                    if (pos == 3'd0) begin
                        p = 3'd1;
                        b = 1'b0;
                    end else begin
                        p = pos - 3'd1;
                    end
                end else if (pos >= LAST) begin
                    p = TURN;
                    b = 1'b1;
                end else begin
                    p = pos + 3'd1;
                end
            end
        endcase
        return {b, p};
    endfunction

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_ov || o_out.ready;

    assign i_in.ready         = (r_state == ssp_pkg::S_IDLE);
    assign o_out.valid        = r_ov;
    assign o_out.step         = r_o_step;
    assign o_out.gate         = r_o_gate;
    assign o_out.step_trigger = r_o_trig;

    assign w_mode_cur = ssp_pkg::mode_of(i_cfg.mode_table, r_pos);
    assign w_eff_pend = r_pend_v || r_fv;
    assign w_eff_step = r_fv ? ((r_fs >= LAST) ? LAST : r_fs) : r_pend_s;

    // jump target of a reset-mode step
    always_comb begin
        case (r_dir)
            ssp_pkg::DIR_FWD:  w_jump_pos = 3'd0;
            ssp_pkg::DIR_BACK: w_jump_pos = LAST;
            default:           w_jump_pos = r_back ? LAST : 3'd0;
        endcase
    end

    // shared search unit: one advance, one mode check and one draw
    assign {w_adv_back, w_adv_pos} = advance(r_pos, r_back, r_dir);
    assign w_adv_mode  = ssp_pkg::mode_of(i_cfg.mode_table, w_adv_pos);
    assign w_adv_prob  = w_adv_mode inside {ssp_pkg::MODE_P75, ssp_pkg::MODE_P50,
                                            ssp_pkg::MODE_P25};
    assign w_lfsr_step = (r_lfsr >> 1) ^ (r_lfsr[0] ? ssp_pkg::LFSR_MASK : 16'h0000);
    assign w_draw      = w_lfsr_step[1:0];

    always_comb begin
        case (w_adv_mode)
            ssp_pkg::MODE_SKIP: w_lose = 1'b1;
            ssp_pkg::MODE_P75:  w_lose = (w_draw > 2'd2);
            ssp_pkg::MODE_P50:  w_lose = (w_draw > 2'd1);
            ssp_pkg::MODE_P25:  w_lose = (w_draw != 2'd0);
            default:            w_lose = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ssp_pkg::S_IDLE: begin
                if (w_accept) n_state = ssp_pkg::S_DECODE;
            end
            ssp_pkg::S_DECODE: begin
                if (r_guard != 16'd0) begin
                    n_state = ssp_pkg::S_DONE;
                end else if (r_rst_e) begin
                    n_state = ssp_pkg::S_PULSE;
                end else if (r_clk_e == ssp_pkg::EDGE_RISE) begin
                    if (w_eff_pend || (w_mode_cur == ssp_pkg::MODE_RESET)) begin
                        n_state = ssp_pkg::S_PULSE;
                    end else begin
                        n_state = ssp_pkg::S_SEARCH;
                    end
                end else begin
                    n_state = ssp_pkg::S_DONE;
                end
            end
            ssp_pkg::S_SEARCH: begin
                if (!w_lose || (r_try == TRY_LAST)) n_state = ssp_pkg::S_PULSE;
            end
            ssp_pkg::S_PULSE: begin
                n_state = ssp_pkg::S_DONE;
            end
            ssp_pkg::S_DONE: begin
                if (w_out_free) n_state = ssp_pkg::S_IDLE;
            end
            default: n_state = ssp_pkg::S_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        n_pos    = r_pos;
        n_back   = r_back;
        n_pend_v = r_pend_v;
        n_pend_s = r_pend_s;
        n_guard  = r_guard;
        n_lfsr   = r_lfsr;
        n_gate   = r_gate;
        n_trig   = r_trig;
        n_try    = r_try;
        n_ov     = r_ov && !o_out.ready;
        case (r_state)
            ssp_pkg::S_DECODE: begin
                n_try = '0;
                if (r_guard != 16'd0) begin
                    n_guard = r_guard - 16'd1;
                    if (r_guard == 16'd1) begin
                        n_gate = 1'b0;
                        n_trig = 1'b0;
                    end
                end else if (r_rst_e) begin
                    n_pos    = (r_dir == ssp_pkg::DIR_BACK) ? LAST : 3'd0;
                    n_back   = 1'b0;
                    n_pend_v = 1'b0;
                    n_guard  = GUARD_LOAD;
                end else begin
                    n_pend_v = w_eff_pend;
                    n_pend_s = w_eff_step;
                    if (r_clk_e == ssp_pkg::EDGE_RISE) begin
                        if (w_eff_pend) begin
                            n_pos    = w_eff_step;
                            n_pend_v = 1'b0;
                        end else if (w_mode_cur == ssp_pkg::MODE_RESET) begin
                            n_pos = w_jump_pos;
                        end
                    end else if (r_clk_e == ssp_pkg::EDGE_FALL) begin
                        if (w_mode_cur != ssp_pkg::MODE_SLIDE) n_gate = 1'b0;
                        n_trig = 1'b0;
                    end
                end
            end
            ssp_pkg::S_SEARCH: begin
                n_pos  = w_adv_pos;
                n_back = w_adv_back;
                if (w_adv_prob) n_lfsr = w_lfsr_step;
                n_try  = r_try + TRY_W'(1);
            end
            ssp_pkg::S_PULSE: begin
                // skip step silences the gate only when reached by a clock
                n_gate = r_rst_e || (w_mode_cur != ssp_pkg::MODE_SKIP);
                n_trig = (ssp_pkg::owner_of(i_cfg.owner_table, r_pos) == i_cfg.lane_id);
            end
            ssp_pkg::S_DONE: begin
                if (w_out_free) n_ov = 1'b1;
            end
            default: begin
            end
        endcase
        if (i_cfg.seed_load) n_lfsr = i_cfg.seed_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ssp_pkg::S_IDLE;
            r_pos    <= 3'd0;
            r_back   <= 1'b0;
            r_pend_v <= 1'b0;
            r_pend_s <= 3'd0;
            r_guard  <= 16'd0;
            r_lfsr   <= ssp_pkg::SEED_RESET;
            r_gate   <= 1'b1;
            r_trig   <= 1'b0;
            r_try    <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_back   <= n_back;
            r_pend_v <= n_pend_v;
            r_pend_s <= n_pend_s;
            r_guard  <= n_guard;
            r_lfsr   <= n_lfsr;
            r_gate   <= n_gate;
            r_trig   <= n_trig;
            r_try    <= n_try;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_clk_e <= i_in.clock_edge;
            r_rst_e <= i_in.reset_edge;
            r_fv    <= i_in.force_valid;
            r_fs    <= i_in.force_step;
            r_dir   <= (i_in.direction > ssp_pkg::DIR_PEND) ? ssp_pkg::DIR_PEND
                                                            : i_in.direction;
        end
        if ((r_state == ssp_pkg::S_DONE) && w_out_free) begin
            r_o_step <= r_pos;
            r_o_gate <= r_gate;
            r_o_trig <= r_trig;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/step_sequencer_position.sv =====
// top level of one step sequencer lane: register file and lane core
// depends on ssp_pkg, ssp_if, ssp_core and step_sequencer_position_defines.svh
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake       word
// i_in      in   valid / ready   clock_edge, reset_edge, force_valid, force_step, direction
// o_out     out  valid / ready   step, gate, step_trigger
// apb       in   psel / penable  paddr, pwdata -> prdata (pready tied high)
//
// states: a word with no rising clock or inside the guard passes decode and done only;
// a reset edge, a forced step or a reset-mode step adds the pulse state, and the step
// search adds search and pulse, up to STEPS tries; the search unit (one advance, mode check
// and lfsr draw) tries one step per cycle
// reset: synchronous on i_rst_n, no clearing pass; lfsr starts at seed 1
// stalls: a finished word waits in the output register while the next sample
// word is taken; the core only stalls in its last state if that register is full

`include "step_sequencer_position_defines.svh"

module step_sequencer_position #(
    parameter int STEPS       = ssp_pkg::STEPS_DEFAULT,
    parameter int GUARD_TICKS = ssp_pkg::GUARD_TICKS_DEFAULT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    ssp_in_if.sink                          i_in,
    ssp_out_if.source                       o_out,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ssp_pkg::APB_AW-1:0] paddr,
    input  wire logic [ssp_pkg::APB_DW-1:0] pwdata,
    output      logic [ssp_pkg::APB_DW-1:0] prdata,
    output      logic                       pready
);

    // configuration registers
    logic [23:0] r_mode_table;
    logic [15:0] r_owner_table;
    logic [1:0]  r_lane_id;
    logic [15:0] r_seed;

    logic          w_wr;
    logic [1:0]    w_idx;
    ssp_pkg::t_cfg w_cfg;

    assign pready = 1'b1;
    // write completes in the access phase
    assign w_wr  = psel && penable && pwrite && pready;
    // word index, byte offset ignored
    assign w_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_table  <= 24'd0;
            r_owner_table <= 16'd0;
            r_lane_id     <= 2'd0;
            r_seed        <= ssp_pkg::SEED_RESET;
        end else if (w_wr) begin
            case (w_idx)
                ssp_pkg::REG_MODE:  r_mode_table  <= pwdata[23:0];
                ssp_pkg::REG_OWNER: r_owner_table <= pwdata[15:0];
                ssp_pkg::REG_LANE:  r_lane_id     <= pwdata[1:0];
                ssp_pkg::REG_SEED:  r_seed        <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            ssp_pkg::REG_MODE:  prdata = {8'd0, r_mode_table};
            ssp_pkg::REG_OWNER: prdata = {16'd0, r_owner_table};
            ssp_pkg::REG_LANE:  prdata = {30'd0, r_lane_id};
            ssp_pkg::REG_SEED:  prdata = {16'd0, r_seed};
            default:            prdata = '0;
        endcase
    end

    // a seed write reloads the lfsr in the same edge; a zero seed loads one
    assign w_cfg.mode_table  = r_mode_table;
    assign w_cfg.owner_table = r_owner_table;
    assign w_cfg.lane_id     = r_lane_id;
    assign w_cfg.seed_load   = w_wr && (w_idx == ssp_pkg::REG_SEED);
    assign w_cfg.seed_value  = (pwdata[15:0] == 16'd0) ? ssp_pkg::SEED_RESET
                                                       : pwdata[15:0];

    ssp_core #(
        .STEPS       (STEPS),
        .GUARD_TICKS (GUARD_TICKS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

    // one sample word in flight: taking a word drops ready on the next cycle
    `SSP_ASSERT_NEXT(a_single_word, i_in.valid && i_in.ready, !i_in.ready)

    // a result word only appears after the core was busy with a sample word
    `SSP_ASSERT_NOW(a_out_after_busy, $rose(o_out.valid), !$past(i_in.ready))

endmodule

`default_nettype wire
